// ===== src/hit_event_box_tracker_top_macros.svh =====
// Assertion macros shared by the box tracker RTL.
// Included by files that carry concurrent checks; no dependencies.
`ifndef HIT_EVENT_BOX_TRACKER_TOP_MACROS_SVH
`define HIT_EVENT_BOX_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HEBT_ASSERT_IMPL(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define HEBT_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`endif

// ===== src/hebt_pkg.sv =====
// Types and constants for the hit event box tracker.
// No dependencies; imported by every other file except the assertion macro header.
`default_nettype none

package hebt_pkg;

    localparam int COORD_W = 7;
    localparam int TIMER_W = 8;
    localparam int MAP_W   = 8;
    localparam int SLOT_W  = 3;
    localparam int SIZE_W  = 5;
    localparam int CNT_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]     MAX_RESULTS = 4'd8;
    localparam logic [TIMER_W-1:0]   KEEP_MASK   = 8'h07;
    localparam logic [MAP_W-1:0]     MAP_WIDTH_RESET  = 8'd64;
    localparam logic [MAP_W-1:0]     MAP_HEIGHT_RESET = 8'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [TIMER_W-1:0] timer_t;
    typedef logic [MAP_W-1:0]   map_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SCAN,
        S_REPORT,
        S_UPDATE
    } state_t;

    typedef enum logic [1:0] {
        MODE_GROW,
        MODE_NEW,
        MODE_EVICT
    } mode_t;

    typedef struct packed {
        coord_t left;
        coord_t right;
        coord_t upper;
        coord_t lower;
        timer_t timer;
    } slot_t;

    typedef struct packed {
        logic  en;
        logic  coord_en;
        slot_t data;
    } wr_t;

    typedef struct packed {
        logic   fit;
        coord_t org_x;
        coord_t org_y;
    } geom_t;

endpackage

`default_nettype wire

// ===== src/hebt_if.sv =====
// Valid/ready channel interfaces for hit items and repaint results.
// Depends on hebt_pkg.
`default_nettype none

interface hebt_item_if;
    import hebt_pkg::*;
    logic   valid;
    logic   ready;
    logic   kind;
    coord_t hit_x;
    coord_t hit_y;
    logic   tile_discovered;

    modport source (output valid, kind, hit_x, hit_y, tile_discovered, input ready);
    modport sink   (input valid, kind, hit_x, hit_y, tile_discovered, output ready);
endinterface

interface hebt_result_if;
    import hebt_pkg::*;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    coord_t            outline_left;
    coord_t            outline_top;
    logic              last;

    modport source (output valid, slot, outline_left, outline_top, last, input ready);
    modport sink   (input valid, slot, outline_left, outline_top, last, output ready);
endinterface

`default_nettype wire

// ===== src/hebt_box_table.sv =====
// Slot table: box coordinates and timers, one combinational read port.
// Depends on hebt_pkg.
`default_nettype none

module hebt_box_table #(
    parameter int NUM_BOXES = 8,
    parameter int IDX_W     = 3
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire [IDX_W-1:0]          rd_idx,
    output hebt_pkg::slot_t          rd,
    input  wire [IDX_W-1:0]          wr_idx,
    input  wire hebt_pkg::wr_t       wr,
    output logic [NUM_BOXES-1:0]     expire_mask
);
    import hebt_pkg::*;

    coord_t left_reg  [NUM_BOXES];
    coord_t right_reg [NUM_BOXES];
    coord_t upper_reg [NUM_BOXES];
    coord_t lower_reg [NUM_BOXES];
    timer_t timer_reg [NUM_BOXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BOXES; i++)
            begin
                timer_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            timer_reg[wr_idx] <= wr.data.timer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.coord_en)
        begin
            left_reg[wr_idx]  <= wr.data.left;
            right_reg[wr_idx] <= wr.data.right;
            upper_reg[wr_idx] <= wr.data.upper;
            lower_reg[wr_idx] <= wr.data.lower;
        end
    end

    always_comb
    begin
        rd.left  = left_reg[rd_idx];
        rd.right = right_reg[rd_idx];
        rd.upper = upper_reg[rd_idx];
        rd.lower = lower_reg[rd_idx];
        rd.timer = timer_reg[rd_idx];
        for (int i = 0; i < NUM_BOXES; i++)
        begin
            expire_mask[i] = (timer_reg[i] == timer_t'(1));
        end
    end

endmodule

`default_nettype wire

// ===== src/hebt_geom_unit.sv =====
// Shared geometry unit: fit test and clamped outline origin for one slot.
// Depends on hebt_pkg.
`default_nettype none

module hebt_geom_unit #(
    parameter int BOX_WIDTH  = 8,
    parameter int BOX_HEIGHT = 5
) (
    input  wire hebt_pkg::slot_t  rd,
    input  wire hebt_pkg::coord_t hit_x,
    input  wire hebt_pkg::coord_t hit_y,
    input  wire hebt_pkg::map_t   map_w,
    input  wire hebt_pkg::map_t   map_h,
    output hebt_pkg::geom_t       geom
);
    import hebt_pkg::*;

    localparam logic [SIZE_W-1:0] BW = SIZE_W'(BOX_WIDTH);
    localparam logic [SIZE_W-1:0] BH = SIZE_W'(BOX_HEIGHT);

    function automatic logic fits_axis(coord_t p, coord_t lo, coord_t hi,
                                       logic [SIZE_W-1:0] size);
        logic signed [9:0] sp;
        logic signed [9:0] slo;
        logic signed [9:0] shi;
        logic signed [9:0] room;
        logic              res;
        sp   = $signed({3'b000, p});
        slo  = $signed({3'b000, lo});
        shi  = $signed({3'b000, hi});
        room = $signed({5'b00000, size}) - (shi - slo);
        if (sp >= slo && sp <= shi)
            res = 1'b1;
        else if (sp < slo)
            res = (slo - sp) < room;
        else
            res = (sp - shi) < room;
        return res;
    endfunction

    function automatic coord_t clamp_origin(coord_t lo, coord_t hi,
                                            logic [SIZE_W-1:0] size, map_t mapsz);
        logic signed [9:0] slo;
        logic signed [9:0] room;
        logic signed [9:0] half;
        logic signed [9:0] t;
        logic signed [9:0] lim;
        logic signed [9:0] res;
        slo  = $signed({3'b000, lo});
        room = $signed({5'b00000, size}) - ($signed({3'b000, hi}) - slo);
        // truncate toward zero
        half = room[9] ? ((room + 10'sd1) >>> 1) : (room >>> 1);
        t    = slo - half;
        lim  = $signed({2'b00, mapsz}) - $signed({5'b00000, size});
        if (lim < 10'sd0)
            lim = 10'sd0;
        if (t < 10'sd0)
            res = 10'sd0;
        else if (t > lim)
            res = lim;
        else
            res = t;
        return res[COORD_W-1:0];
    endfunction

    always_comb
    begin
        geom.fit   = fits_axis(hit_x, rd.left, rd.right, BW)
                     && fits_axis(hit_y, rd.upper, rd.lower, BH);
        geom.org_x = clamp_origin(rd.left, rd.right, BW, map_w);
        geom.org_y = clamp_origin(rd.upper, rd.lower, BH, map_h);
    end

endmodule

`default_nettype wire

// ===== src/hebt_seq.sv =====
// Sequencer: slot scan, tick countdown, table updates and the result register.
// Depends on hebt_pkg, hebt_if and the assertion macro header.
`default_nettype none
`include "hit_event_box_tracker_top_macros.svh"

module hebt_seq #(
    parameter int NUM_BOXES  = 8,
    parameter int HOLD_TICKS = 128,
    parameter int IDX_W      = 3
) (
    input  wire                  clk,
    input  wire                  rst_n,
    hebt_item_if.sink            item,
    hebt_result_if.source        result,
    output logic [IDX_W-1:0]     rd_idx,
    input  wire hebt_pkg::slot_t rd,
    input  wire hebt_pkg::geom_t geom,
    output logic [IDX_W-1:0]     wr_idx,
    output hebt_pkg::wr_t        wr,
    input  wire [NUM_BOXES-1:0]  expire_mask,
    output hebt_pkg::coord_t     hit_x,
    output hebt_pkg::coord_t     hit_y
);
    import hebt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BOXES - 1);
    localparam timer_t           HOLD     = TIMER_W'(HOLD_TICKS);

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     chosen_reg, chosen_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]     min_idx_reg, min_idx_next;
    logic                 free_found_reg, free_found_next;
    timer_t               best_reg, best_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_BOXES-1:0] mask_reg, mask_next;
    coord_t               x_reg, x_next;
    coord_t               y_reg, y_next;

    logic                 res_valid_reg, res_valid_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    coord_t               res_left_reg, res_left_next;
    coord_t               res_top_reg, res_top_next;
    logic                 res_last_reg, res_last_next;

    logic                 out_free;
    logic                 load;
    logic                 load_last;
    logic [IDX_W-1:0]     load_idx;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [NUM_BOXES-1:0] cur_bit;
    logic [NUM_BOXES-1:0] rest;
    logic                 active;
    logic                 expire;
    logic                 report_now;
    logic                 take_min;

    assign out_free   = !res_valid_reg || result.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign hit_x      = x_reg;
    assign hit_y      = y_reg;

    assign result.valid        = res_valid_reg;
    assign result.slot         = res_slot_reg;
    assign result.outline_left = res_left_reg;
    assign result.outline_top  = res_top_reg;
    assign result.last         = res_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_NEW;
            idx_reg        <= '0;
            chosen_reg     <= '0;
            free_idx_reg   <= '0;
            min_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            best_reg       <= '0;
            cnt_reg        <= '0;
            mask_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            idx_reg        <= idx_next;
            chosen_reg     <= chosen_next;
            free_idx_reg   <= free_idx_next;
            min_idx_reg    <= min_idx_next;
            free_found_reg <= free_found_next;
            best_reg       <= best_next;
            cnt_reg        <= cnt_next;
            mask_reg       <= mask_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        res_slot_reg <= res_slot_next;
        res_left_reg <= res_left_next;
        res_top_reg  <= res_top_next;
        res_last_reg <= res_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        chosen_next     = chosen_reg;
        free_idx_next   = free_idx_reg;
        min_idx_next    = min_idx_reg;
        free_found_next = free_found_reg;
        best_next       = best_reg;
        cnt_next        = cnt_reg;
        mask_next       = mask_reg;
        x_next          = x_reg;
        y_next          = y_reg;

        load      = 1'b0;
        load_last = 1'b1;
        load_idx  = chosen_reg;

        wr        = '0;
        wr_idx    = idx_reg;

        rd_idx = (state_reg == S_REPORT || state_reg == S_UPDATE) ? chosen_reg : idx_reg;

        cur_bit = '0;
        cur_bit[idx_reg] = 1'b1;
        rest       = mask_reg & ~cur_bit;
        active     = (rd.timer != '0);
        expire     = (rd.timer == timer_t'(1));
        report_now = expire && (cnt_reg < MAX_RESULTS);
        take_min   = (idx_reg == '0) || (rd.timer <= best_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    x_next          = item.hit_x;
                    y_next          = item.hit_y;
                    idx_next        = '0;
                    cnt_next        = '0;
                    free_found_next = 1'b0;
                    mask_next       = expire_mask;
                    if (item.kind)
                        state_next = S_TICK;
                    else if (item.tile_discovered)
                        state_next = S_SCAN;
                end
            end

            S_TICK:
            begin
                if (!(report_now && !out_free))
                begin
                    if (active)
                    begin
                        wr.en         = 1'b1;
                        wr.data.timer = rd.timer - timer_t'(1);
                    end
                    if (report_now)
                    begin
                        load      = 1'b1;
                        load_idx  = idx_reg;
                        load_last = (rest == '0) || (cnt_reg == MAX_RESULTS - CNT_W'(1));
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                    mask_next = rest;
                    if (idx_reg == LAST_IDX)
                        state_next = S_IDLE;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_SCAN:
            begin
                if (!active && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (take_min)
                begin
                    min_idx_next = idx_reg;
                    best_next    = rd.timer;
                end
                if (active && geom.fit)
                begin
                    chosen_next = idx_reg;
                    mode_next   = MODE_GROW;
                    state_next  = S_REPORT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    if (free_found_next)
                    begin
                        chosen_next = free_idx_next;
                        mode_next   = MODE_NEW;
                        state_next  = S_UPDATE;
                    end
                    else
                    begin
                        chosen_next = min_idx_next;
                        mode_next   = MODE_EVICT;
                        state_next  = S_REPORT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_REPORT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                wr.en       = 1'b1;
                wr.coord_en = 1'b1;
                wr_idx      = chosen_reg;
                if (mode_reg == MODE_GROW)
                begin
                    wr.data.left  = (x_reg < rd.left)  ? x_reg : rd.left;
                    wr.data.right = (x_reg > rd.right) ? x_reg : rd.right;
                    wr.data.upper = (y_reg < rd.upper) ? y_reg : rd.upper;
                    wr.data.lower = (y_reg > rd.lower) ? y_reg : rd.lower;
                    wr.data.timer = (rd.timer & KEEP_MASK) + HOLD;
                end
                else
                begin
                    wr.data.left  = x_reg;
                    wr.data.right = x_reg;
                    wr.data.upper = y_reg;
                    wr.data.lower = y_reg;
                    wr.data.timer = HOLD;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        slot_ext       = {{SLOT_W{1'b0}}, load_idx};
        res_valid_next = load || (res_valid_reg && !result.ready);
        res_slot_next  = res_slot_reg;
        res_left_next  = res_left_reg;
        res_top_next   = res_top_reg;
        res_last_next  = res_last_reg;
        if (load)
        begin
            res_slot_next = slot_ext[SLOT_W-1:0];
            res_left_next = geom.org_x;
            res_top_next  = geom.org_y;
            res_last_next = load_last;
        end
    end

    `HEBT_ASSERT_IMPL(a_idle_no_write, clk, rst_n, state_reg == S_IDLE, !wr.en, "table written while idle")
    `HEBT_ASSERT_IMPL(a_cnt_cap, clk, rst_n, state_reg == S_TICK, cnt_reg <= MAX_RESULTS, "tick result count above limit")
    `HEBT_ASSERT_IMPL(a_grow_active, clk, rst_n, state_reg == S_UPDATE && mode_reg == MODE_GROW, rd.timer != '0, "growing a free slot")
    `HEBT_ASSERT_IMPL(a_update_live, clk, rst_n, state_reg == S_UPDATE, wr.en && wr.coord_en && wr.data.timer != '0, "updated slot left free")
    `HEBT_ASSERT_NEXT(a_report_loads, clk, rst_n, state_reg == S_REPORT && out_free, res_valid_reg && res_last_reg, "hit report not registered")

endmodule

`default_nettype wire

// ===== src/hit_event_box_tracker_top.sv =====
// Top level of the hit event box tracker: map registers, slot table,
// geometry unit and sequencer. Depends on hebt_pkg, hebt_if and the submodules.
//
//  channel  | dir | handshake      | payload
//  item     | in  | valid/ready    | kind, hit_x, hit_y, tile_discovered
//  result   | out | valid/ready    | slot, outline_left, outline_top, last
//  wr_*     | in  | wr_en only     | wr_index, wr_data (map_width, map_height)
//
// Every transaction is accepted in the idle state.
// A tick then walks every slot through the table port, one slot counted down per cycle
// unless a stalled result register holds it. A hit then scans up to NUM_BOXES slots, then
// reports when it grows or evicts a box, then updates; an undiscovered hit is only accepted.
// Reset clears all timers at once, so every slot is free; no clearing pass.
// A stalled result register holds the sequencer on the cycle that would load it.
`default_nettype none

module hit_event_box_tracker_top #(
    parameter int NUM_BOXES  = 8,
    parameter int HOLD_TICKS = 128,
    parameter int BOX_WIDTH  = 8,
    parameter int BOX_HEIGHT = 5
) (
    input  wire                              clk,
    input  wire                              rst_n,
    hebt_item_if.sink                        item,
    hebt_result_if.source                    result,
    input  wire                              wr_en,
    input  wire [hebt_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire [hebt_pkg::MAP_W-1:0]        wr_data
);
    import hebt_pkg::*;

    localparam int IDX_W = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;

    map_t                 map_w_reg;
    map_t                 map_h_reg;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     wr_idx;
    slot_t                rd;
    wr_t                  wr;
    geom_t                geom;
    logic [NUM_BOXES-1:0] expire_mask;
    coord_t               hit_x;
    coord_t               hit_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg <= MAP_WIDTH_RESET;
            map_h_reg <= MAP_HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_MAP_WIDTH:  map_w_reg <= wr_data;
                CFG_MAP_HEIGHT: map_h_reg <= wr_data;
                default:        ;
            endcase
        end
    end

    hebt_box_table #(
        .NUM_BOXES (NUM_BOXES),
        .IDX_W     (IDX_W)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_idx      (rd_idx),
        .rd          (rd),
        .wr_idx      (wr_idx),
        .wr          (wr),
        .expire_mask (expire_mask)
    );

    hebt_geom_unit #(
        .BOX_WIDTH  (BOX_WIDTH),
        .BOX_HEIGHT (BOX_HEIGHT)
    ) u_geom (
        .rd    (rd),
        .hit_x (hit_x),
        .hit_y (hit_y),
        .map_w (map_w_reg),
        .map_h (map_h_reg),
        .geom  (geom)
    );

    hebt_seq #(
        .NUM_BOXES  (NUM_BOXES),
        .HOLD_TICKS (HOLD_TICKS),
        .IDX_W      (IDX_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .rd_idx      (rd_idx),
        .rd          (rd),
        .geom        (geom),
        .wr_idx      (wr_idx),
        .wr          (wr),
        .expire_mask (expire_mask),
        .hit_x       (hit_x),
        .hit_y       (hit_y)
    );

endmodule

`default_nettype wire

// ===== sim/hit_event_box_tracker_top_tb.sv =====
// Self-checking testbench for hit_event_box_tracker_top: drives hit and tick transactions,
// predicts every repaint report and compares it field by field at the result channel.
// Depends on hebt_pkg, hebt_if and the tracker RTL.
`default_nettype none

module hit_event_box_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hebt_pkg::*;

    localparam int NUM_BOXES     = 8;
    localparam int HOLD_TICKS    = 128;
    localparam int BOX_WIDTH     = 8;
    localparam int BOX_HEIGHT    = 5;
    localparam int SETTLE_CYCLES = 2 * NUM_BOXES + 8;
    localparam int HOLD_SPAN     = 220;
    localparam int MAX_PRINTS    = 50;

    typedef struct packed {
        logic   kind;
        coord_t x;
        coord_t y;
        logic   disc;
    } hit_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        coord_t            left;
        coord_t            top;
        logic              last;
    } repaint_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    map_t               wr_data;

    hebt_item_if   item_ch ();
    hebt_result_if result_ch ();

    hit_event_box_tracker_top #(
        .NUM_BOXES  (NUM_BOXES),
        .HOLD_TICKS (HOLD_TICKS),
        .BOX_WIDTH  (BOX_WIDTH),
        .BOX_HEIGHT (BOX_HEIGHT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #2 clk = ~clk;

    // box table shadow
    map_t   map_w;
    map_t   map_h;
    coord_t box_left  [NUM_BOXES];
    coord_t box_right [NUM_BOXES];
    coord_t box_upper [NUM_BOXES];
    coord_t box_lower [NUM_BOXES];
    timer_t box_timer [NUM_BOXES];

    hit_item_t pending [$];
    repaint_t  repaint_q [$];

    hit_item_t tx_cur;
    logic      tx_next;
    int        tx_pause = 0;
    logic      rx_next;
    int        rx_pause = 0;
    logic      hold_rx = 1'b0;
    int        calm_left [2] = '{0, 0};

    int n_accepted = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_ticks    = 0;
    int n_ignored  = 0;
    int n_new      = 0;
    int n_grows    = 0;
    int n_evicts   = 0;
    int n_expiries = 0;
    int n_multi    = 0;

    task automatic flag_mismatch(input string what);
        if (n_errors < MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        n_errors++;
    endtask

    function automatic int draw_pause(input int side);
        int r;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left[side] = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit span_fits(input int p, input int lo, input int hi, input int size);
        int room;
        room = size - (hi - lo);
        if (p >= lo && p <= hi) return 1'b1;
        if (p < lo) return (lo - p) < room;
        return (p - hi) < room;
    endfunction

    function automatic coord_t outline_origin(input int lo, input int hi, input int size,
                                              input int mapsz);
        int t;
        int lim;
        t   = lo - (size - (hi - lo)) / 2;
        lim = mapsz - size;
        if (lim < 0) lim = 0;
        if (t < 0) t = 0;
        else if (t > lim) t = lim;
        return coord_t'(t);
    endfunction

    function automatic repaint_t outline_of(input int i);
        repaint_t r;
        r.slot = SLOT_W'(i);
        r.left = outline_origin(int'(box_left[i]), int'(box_right[i]), BOX_WIDTH, int'(map_w));
        r.top  = outline_origin(int'(box_upper[i]), int'(box_lower[i]), BOX_HEIGHT, int'(map_h));
        r.last = 1'b0;
        return r;
    endfunction

    task automatic track_item(input hit_item_t it);
        repaint_t found [$];
        int       chosen;
        int       best;
        if (it.kind) begin
            n_ticks++;
            for (int i = 0; i < NUM_BOXES; i++) begin
                if (box_timer[i] != '0) begin
                    box_timer[i] = box_timer[i] - 1'b1;
                    if (box_timer[i] == '0 && found.size() < int'(MAX_RESULTS)) begin
                        found.push_back(outline_of(i));
                        n_expiries++;
                    end
                end
            end
            if (found.size() > 1) n_multi++;
        end else if (!it.disc) begin
            n_ignored++;
        end else begin
            chosen = -1;
            for (int i = 0; i < NUM_BOXES; i++) begin
                if (box_timer[i] != '0 &&
                    span_fits(int'(it.x), int'(box_left[i]), int'(box_right[i]), BOX_WIDTH) &&
                    span_fits(int'(it.y), int'(box_upper[i]), int'(box_lower[i]), BOX_HEIGHT))
                begin
                    chosen = i;
                    break;
                end
                if (box_timer[i] == '0 && chosen < 0) chosen = i;
            end
            if (chosen < 0) begin
                best = 256;
                for (int i = 0; i < NUM_BOXES; i++) begin
                    if (int'(box_timer[i]) <= best) begin
                        chosen = i;
                        best   = int'(box_timer[i]);
                    end
                end
                found.push_back(outline_of(chosen));
                box_timer[chosen] = '0;
                n_evicts++;
            end
            if (box_timer[chosen] == '0) begin
                box_left[chosen]  = it.x;
                box_right[chosen] = it.x;
                box_upper[chosen] = it.y;
                box_lower[chosen] = it.y;
                box_timer[chosen] = timer_t'(HOLD_TICKS);
                n_new++;
            end else begin
                found.push_back(outline_of(chosen));
                if (it.x < box_left[chosen])  box_left[chosen]  = it.x;
                if (it.x > box_right[chosen]) box_right[chosen] = it.x;
                if (it.y < box_upper[chosen]) box_upper[chosen] = it.y;
                if (it.y > box_lower[chosen]) box_lower[chosen] = it.y;
                box_timer[chosen] = timer_t'((box_timer[chosen] & KEEP_MASK) + HOLD_TICKS);
                n_grows++;
            end
        end
        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        foreach (found[k]) repaint_q.push_back(found[k]);
    endtask

    // driver
    always @(posedge clk) begin
        tx_next = item_ch.valid;
        if (item_ch.valid && item_ch.ready) begin
            track_item(tx_cur);
            n_accepted++;
            tx_next  = 1'b0;
            tx_pause = draw_pause(0);
        end
        if (rst_n && !tx_next) begin
            if (tx_pause > 0) begin
                tx_pause--;
            end else if (pending.size() != 0) begin
                tx_cur = pending.pop_front();
                item_ch.kind            <= tx_cur.kind;
                item_ch.hit_x           <= tx_cur.x;
                item_ch.hit_y           <= tx_cur.y;
                item_ch.tile_discovered <= tx_cur.disc;
                tx_next = 1'b1;
            end
        end
        item_ch.valid <= tx_next;
    end

    // monitor
    always @(posedge clk) begin
        if (result_ch.valid && result_ch.ready) begin
            if (repaint_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected repaint slot %0d left %0d top %0d last %0b",
                              result_ch.slot, result_ch.outline_left, result_ch.outline_top,
                              result_ch.last));
            end else begin
                repaint_t e;
                e = repaint_q.pop_front();
                n_checked++;
                if (result_ch.slot !== e.slot)
                    flag_mismatch($sformatf("slot got %0d want %0d", result_ch.slot, e.slot));
                if (result_ch.outline_left !== e.left)
                    flag_mismatch($sformatf("outline_left got %0d want %0d (slot %0d)",
                                  result_ch.outline_left, e.left, e.slot));
                if (result_ch.outline_top !== e.top)
                    flag_mismatch($sformatf("outline_top got %0d want %0d (slot %0d)",
                                  result_ch.outline_top, e.top, e.slot));
                if (result_ch.last !== e.last)
                    flag_mismatch($sformatf("last got %0b want %0b (slot %0d)",
                                  result_ch.last, e.last, e.slot));
            end
            rx_pause = draw_pause(1);
        end else if (rx_pause == 0 && $urandom_range(0, 15) == 0) begin
            rx_pause = draw_pause(1);
        end
        if (!rst_n || hold_rx) begin
            rx_next = 1'b0;
        end else if (rx_pause > 0) begin
            rx_pause--;
            rx_next = 1'b0;
        end else begin
            rx_next = 1'b1;
        end
        result_ch.ready <= rx_next;
    end

    // long receiver stall while hits keep arriving
    initial begin
        while (n_accepted < 30) @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_SPAN) @(posedge clk);
        hold_rx <= 1'b0;
    end

    function automatic hit_item_t mk_hit(input int x, input int y, input bit disc);
        hit_item_t t;
        t.kind = 1'b0;
        t.x    = coord_t'(x);
        t.y    = coord_t'(y);
        t.disc = disc;
        return t;
    endfunction

    function automatic hit_item_t mk_tick();
        hit_item_t t;
        t.kind = 1'b1;
        t.x    = coord_t'($urandom);
        t.y    = coord_t'($urandom);
        t.disc = 1'($urandom);
        return t;
    endfunction

    function automatic int jitter(input int c);
        int v;
        v = c + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 127) v = 127;
        return v;
    endfunction

    task automatic queue_directed();
        int gx;
        int gy;
        // one box per slot, corners of the map included
        for (int i = 0; i < NUM_BOXES; i++) begin
            gx = (i == NUM_BOXES - 1) ? 127 : 16 * i;
            gy = (i == NUM_BOXES - 1) ? 127 : 16 * i;
            pending.push_back(mk_hit(gx, gy, 1'b1));
        end
        pending.push_back(mk_hit(64, 8, 1'b0));
        repeat (3) pending.push_back(mk_tick());
        // grow every box: all timers end above the hold value
        for (int i = 0; i < NUM_BOXES; i++) begin
            gx = (i == NUM_BOXES - 1) ? 126 : 16 * i + 1;
            gy = (i == NUM_BOXES - 1) ? 126 : 16 * i + 1;
            pending.push_back(mk_hit(gx, gy, 1'b1));
        end
        // table full, no fit: equal timers evict the last slot
        pending.push_back(mk_hit(8, 100, 1'b1));
        pending.push_back(mk_hit(127, 0, 1'b1));
    endtask

    task automatic queue_mixed(input int count);
        int cx [10];
        int cy [10];
        int r;
        int c;
        foreach (cx[k]) begin
            cx[k] = $urandom_range(0, 127);
            cy[k] = $urandom_range(0, 127);
        end
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            c = $urandom_range(0, 9);
            if (r < 15)
                pending.push_back(mk_tick());
            else if (r < 23)
                pending.push_back(mk_hit($urandom_range(0, 127), $urandom_range(0, 127), 1'b0));
            else if (r < 30)
                pending.push_back(mk_hit($urandom_range(0, 127), $urandom_range(0, 127), 1'b1));
            else
                pending.push_back(mk_hit(jitter(cx[c]), jitter(cy[c]), 1'b1));
        end
    endtask

    // boxes made back to back expire on the same tick
    task automatic queue_tick_run();
        queue_mixed(0);
        for (int n = 0; n < 10; n++)
            pending.push_back(mk_hit($urandom_range(0, 127), $urandom_range(0, 127), 1'b1));
        repeat (3) pending.push_back(mk_tick());
        for (int n = 0; n < 4; n++)
            pending.push_back(mk_hit($urandom_range(0, 127), $urandom_range(0, 127), 1'b1));
        repeat (HOLD_TICKS + 2) pending.push_back(mk_tick());
    endtask

    task automatic settle();
        while (pending.size() != 0 || item_ch.valid || repaint_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_map(input logic [CFG_IDX_W-1:0] idx, input map_t value);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == CFG_MAP_WIDTH) map_w = value;
        else if (idx == CFG_MAP_HEIGHT) map_h = value;
    endtask

    initial begin
        map_w = MAP_WIDTH_RESET;
        map_h = MAP_HEIGHT_RESET;
        for (int i = 0; i < NUM_BOXES; i++) begin
            box_left[i]  = '0;
            box_right[i] = '0;
            box_upper[i] = '0;
            box_lower[i] = '0;
            box_timer[i] = '0;
        end
        rst_n                   = 1'b0;
        wr_en                   = 1'b0;
        wr_index                = '0;
        wr_data                 = '0;
        item_ch.valid           = 1'b0;
        item_ch.kind            = 1'b0;
        item_ch.hit_x           = '0;
        item_ch.hit_y           = '0;
        item_ch.tile_discovered = 1'b0;
        result_ch.ready         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        queue_mixed(50);
        settle();

        write_map(CFG_MAP_WIDTH, 8'd8);
        write_map(CFG_MAP_HEIGHT, 8'd5);
        queue_mixed(50);
        settle();

        write_map(CFG_MAP_WIDTH, 8'd128);
        write_map(CFG_MAP_HEIGHT, 8'd128);
        queue_tick_run();
        settle();

        write_map(CFG_MAP_WIDTH, map_t'($urandom_range(9, 127)));
        write_map(CFG_MAP_HEIGHT, map_t'($urandom_range(6, 127)));
        queue_mixed(50);
        settle();

        if (repaint_q.size() != 0)
            flag_mismatch($sformatf("%0d repaint reports never arrived", repaint_q.size()));

        $display("Covered %0d transactions: %0d ticks, %0d ignored hits, %0d new boxes,",
                 n_accepted, n_ticks, n_ignored, n_new);
        $display("  %0d grows, %0d evictions, %0d expiries (%0d multi-expiry ticks), %0d reports",
                 n_grows, n_evicts, n_expiries, n_multi, n_checked);
        if (n_errors == 0) begin
            $display("hit_event_box_tracker_top_tb: done, clean");
        end else begin
            $display("hit_event_box_tracker_top_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout: run did not drain");
        $display("hit_event_box_tracker_top_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
